@@ rtl/link_open_set_ua_handshake_unit_defines.svh @@
// Assertion macros for the top-level RTL file, which checks itself.
`ifndef LINK_OPEN_SET_UA_HANDSHAKE_UNIT_DEFINES_SVH
`define LINK_OPEN_SET_UA_HANDSHAKE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define LOSU_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

`define LOSU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`else

`define LOSU_ASSERT_SAME(label, clk, rst_n, cond, expr)

`define LOSU_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

@@ rtl/losu_pkg.sv @@
`default_nettype none

package losu_pkg;

    localparam int unsigned MODE_W      = 2;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned TIMER_W     = 16;
    localparam int unsigned SENDS_W     = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned BEAT_IDX_W  = 3;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENDS     = 2'd1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET   = 16'd3;
    localparam logic [SENDS_W-1:0] MAX_SENDS_RESET = 4'd3;

    localparam logic [BYTE_W-1:0] FRAME_FLAG = 8'h7E;
    localparam logic [BYTE_W-1:0] ADDR_BYTE  = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_SET   = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_UA    = 8'h07;

    localparam logic [BEAT_IDX_W-1:0] SET_LAST_IDX = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TX   = 2'd0,
        KIND_UP   = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } desc_t;

    function automatic logic [BYTE_W-1:0] set_byte(input logic [BEAT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = FRAME_FLAG;
            3'd1:    b = ADDR_BYTE;
            3'd2:    b = CTRL_SET;
            3'd3:    b = ADDR_BYTE ^ CTRL_SET;
            3'd4:    b = FRAME_FLAG;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/losu_if.sv @@
`default_nettype none

interface losu_in_if;
    logic                              valid;
    logic                              ready;
    logic [losu_pkg::MODE_W-1:0]       mode;
    logic [losu_pkg::BYTE_W-1:0]       rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface losu_out_if;
    logic                              valid;
    logic                              ready;
    logic [losu_pkg::KIND_W-1:0]       kind;
    logic [losu_pkg::BYTE_W-1:0]       tx_byte;
    logic                              last;

    modport source (output valid, output kind, output tx_byte, output last, input ready);
    modport sink (input valid, input kind, input tx_byte, input last, output ready);
endinterface

interface losu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [losu_pkg::CFG_IDX_W-1:0]    index;
    logic [losu_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/losu_core.sv @@
`default_nettype none

// Holds link state; takes one beat per cycle unless stalled; registers each response.
module losu_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    losu_in_if.sink                item,
    losu_cfg_if.sink               cfg,
    output losu_pkg::desc_t        desc,
    input  wire logic              desc_ready
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_UP   = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        PS_FLAG = 3'd0,
        PS_ADDR = 3'd1,
        PS_CTRL = 3'd2,
        PS_CHK  = 3'd3,
        PS_END  = 3'd4
    } parse_t;

    logic [losu_pkg::TIMER_W-1:0] timeout_reg;
    logic [losu_pkg::SENDS_W-1:0] max_sends_reg;
    phase_t                       phase_reg, phase_next;
    parse_t                       parse_reg, parse_next;
    logic [losu_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [losu_pkg::SENDS_W-1:0] sends_reg, sends_next;
    losu_pkg::desc_t              desc_reg, desc_next;

    logic                         accept;
    logic                         ua_done;
    logic [losu_pkg::TIMER_W-1:0] reload;
    logic [losu_pkg::SENDS_W-1:0] limit;

    assign item.ready = !desc_reg.valid || desc_ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign desc       = desc_reg;

    assign reload = (timeout_reg == '0) ? losu_pkg::TIMER_W'(1) : timeout_reg;
    assign limit  = (max_sends_reg == '0) ? losu_pkg::SENDS_W'(1) : max_sends_reg;

    always_comb
    begin
        ua_done    = 1'b0;
        parse_next = (item.rx_byte == losu_pkg::FRAME_FLAG) ? PS_ADDR : PS_FLAG;
        unique case (parse_reg)
            PS_FLAG:
            begin
            end
            PS_ADDR:
            begin
                if (item.rx_byte == losu_pkg::ADDR_BYTE)
                begin
                    parse_next = PS_CTRL;
                end
            end
            PS_CTRL:
            begin
                if (item.rx_byte == losu_pkg::CTRL_UA)
                begin
                    parse_next = PS_CHK;
                end
            end
            PS_CHK:
            begin
                if (item.rx_byte == (losu_pkg::CTRL_UA ^ losu_pkg::ADDR_BYTE))
                begin
                    parse_next = PS_END;
                end
            end
            PS_END:
            begin
                ua_done    = (item.rx_byte == losu_pkg::FRAME_FLAG);
                parse_next = PS_FLAG;
            end
            default:
            begin
                parse_next = PS_FLAG;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        sends_next = sends_reg;
        desc_next  = desc_reg;
        if (desc_ready)
        begin
            desc_next.valid = 1'b0;
        end
        if (accept)
        begin
            if (item.mode == losu_pkg::MODE_START)
            begin
                phase_next     = PH_WAIT;
                sends_next     = losu_pkg::SENDS_W'(1);
                timer_next     = reload;
                desc_next.valid = 1'b1;
                desc_next.kind  = losu_pkg::KIND_TX;
            end
            else if (phase_reg == PH_WAIT && item.mode == losu_pkg::MODE_BYTE)
            begin
                if (ua_done)
                begin
                    phase_next      = PH_UP;
                    timer_next      = '0;
                    desc_next.valid = 1'b1;
                    desc_next.kind  = losu_pkg::KIND_UP;
                end
            end
            else if (phase_reg == PH_WAIT && item.mode == losu_pkg::MODE_TICK)
            begin
                if (timer_reg > losu_pkg::TIMER_W'(1))
                begin
                    timer_next = timer_reg - losu_pkg::TIMER_W'(1);
                end
                else if (sends_reg < limit)
                begin
                    sends_next      = sends_reg + losu_pkg::SENDS_W'(1);
                    timer_next      = reload;
                    desc_next.valid = 1'b1;
                    desc_next.kind  = losu_pkg::KIND_TX;
                end
                else
                begin
                    phase_next      = PH_FAIL;
                    timer_next      = '0;
                    desc_next.valid = 1'b1;
                    desc_next.kind  = losu_pkg::KIND_FAIL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= losu_pkg::TIMEOUT_RESET;
            max_sends_reg <= losu_pkg::MAX_SENDS_RESET;
            phase_reg     <= PH_IDLE;
            parse_reg     <= PS_FLAG;
            timer_reg     <= '0;
            sends_reg     <= '0;
            desc_reg      <= '{valid: 1'b0, kind: losu_pkg::KIND_TX};
        end
        else
        begin
            if (cfg.valid && cfg.index == losu_pkg::CFG_TIMEOUT_TICKS)
            begin
                timeout_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == losu_pkg::CFG_MAX_SENDS)
            begin
                max_sends_reg <= cfg.data[losu_pkg::SENDS_W-1:0];
            end
            if (accept && item.mode == losu_pkg::MODE_START)
            begin
                parse_reg <= PS_FLAG;
            end
            else if (accept && phase_reg == PH_WAIT && item.mode == losu_pkg::MODE_BYTE)
            begin
                parse_reg <= parse_next;
            end
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            sends_reg <= sends_next;
            desc_reg  <= desc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/losu_tx.sv @@
`default_nettype none

// Turns a registered response into output beats: five frame bytes or one status beat.
module losu_tx (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  losu_pkg::desc_t        desc,
    output logic                   desc_ready,
    losu_out_if.source             result
);

    logic                                busy_reg;
    losu_pkg::kind_t                     kind_reg;
    logic [losu_pkg::BEAT_IDX_W-1:0]     idx_reg;
    logic                                last_beat;
    logic                                fire;

    assign last_beat  = (kind_reg != losu_pkg::KIND_TX) || (idx_reg == losu_pkg::SET_LAST_IDX);
    assign fire       = busy_reg && result.ready;
    assign desc_ready = !busy_reg || (result.ready && last_beat);

    assign result.valid   = busy_reg;
    assign result.kind    = kind_reg;
    assign result.last    = last_beat;
    assign result.tx_byte = (kind_reg == losu_pkg::KIND_TX) ? losu_pkg::set_byte(idx_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            kind_reg <= losu_pkg::KIND_TX;
            idx_reg  <= '0;
        end
        else
        begin
            if (desc.valid && desc_ready)
            begin
                busy_reg <= 1'b1;
                kind_reg <= desc.kind;
                idx_reg  <= '0;
            end
            else if (fire && last_beat)
            begin
                busy_reg <= 1'b0;
            end
            else if (fire)
            begin
                idx_reg <= idx_reg + losu_pkg::BEAT_IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/link_open_set_ua_handshake_unit.sv @@
// Link-open handshake: sends SET frames, watches for UA, reports link up or failure.
// A result beat passes through the core's response register, then the tx beat register.
// Throughput: one input beat per cycle unless a response waits; each SET frame is 5 beats.
// Reset (rst_n, asynchronous, active low) clears the link state and restores
// timeout_ticks and max_sends to 3.
`default_nettype none

`include "link_open_set_ua_handshake_unit_defines.svh"

module link_open_set_ua_handshake_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    losu_in_if.sink      item,
    losu_out_if.source   result,
    losu_cfg_if.sink     cfg
);

    losu_pkg::desc_t desc;
    logic            desc_ready;

    losu_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .desc       (desc),
        .desc_ready (desc_ready)
    );

    losu_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc),
        .desc_ready (desc_ready),
        .result     (result)
    );

    `LOSU_ASSERT_NEXT(a_desc_hold, clk, rst_n, desc.valid && !desc_ready, desc.valid && $stable(desc.kind))
    `LOSU_ASSERT_NEXT(a_start_sends, clk, rst_n, item.valid && item.ready && item.mode == losu_pkg::MODE_START, desc.valid && desc.kind == losu_pkg::KIND_TX)
    `LOSU_ASSERT_SAME(a_status_last, clk, rst_n, result.valid && result.kind != losu_pkg::KIND_TX, result.last && result.tx_byte == 8'h00)
    `LOSU_ASSERT_SAME(a_frame_closes, clk, rst_n, result.valid && result.last && result.kind == losu_pkg::KIND_TX, result.tx_byte == losu_pkg::FRAME_FLAG)

endmodule

`default_nettype wire

@@ tb/tb_link_open_set_ua_handshake_unit.sv @@
`default_nettype none

module tb_link_open_set_ua_handshake_unit;

    import losu_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam logic [BYTE_W-1:0] SET_CHECK    = ADDR_BYTE ^ CTRL_SET;
    localparam logic [BYTE_W-1:0] UA_CHECK     = ADDR_BYTE ^ CTRL_UA;
    localparam logic [5*BYTE_W-1:0] SET_FRAME  =
        {FRAME_FLAG, ADDR_BYTE, CTRL_SET, SET_CHECK, FRAME_FLAG};
    localparam logic [5*BYTE_W-1:0] UA_FRAME   =
        {FRAME_FLAG, ADDR_BYTE, CTRL_UA, UA_CHECK, FRAME_FLAG};
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_WAIT,
        LINK_UP,
        LINK_FAILED
    } link_state_t;

    typedef struct {
        kind_t             kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
    } result_beat_t;

    logic clk;
    logic rst_n;

    losu_in_if  in_bus ();
    losu_out_if out_bus ();
    losu_cfg_if cfg_bus ();

    link_open_set_ua_handshake_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_bus),
        .result (out_bus),
        .cfg    (cfg_bus)
    );

    link_state_t        link_state;
    logic [2:0]         ua_state;
    logic [TIMER_W-1:0] ticks_left;
    logic [SENDS_W-1:0] set_count;
    logic [TIMER_W-1:0] cfg_timeout;
    logic [SENDS_W-1:0] cfg_max_sends;

    result_beat_t pending_beats[$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  random_items;
    int unsigned  ua_pos;
    bit           calm;
    int unsigned  sink_level;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL link_open_set_ua_handshake_unit");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        $display("mismatch: %s expected %0h got %0h", what, want_v, got_v);
        error_count++;
    endtask

    task automatic queue_set_frame();
        result_beat_t b;
        for (int k = 0; k < 5; k++)
        begin
            b.kind    = KIND_TX;
            b.tx_byte = SET_FRAME[BYTE_W*(4-k) +: BYTE_W];
            b.last    = (k == 4);
            pending_beats.push_back(b);
        end
        ticks_left = (cfg_timeout == 0) ? TIMER_W'(1) : cfg_timeout;
    endtask

    task automatic queue_status(input kind_t k);
        result_beat_t b;
        b.kind    = k;
        b.tx_byte = '0;
        b.last    = 1'b1;
        pending_beats.push_back(b);
    endtask

    task automatic predict_beat(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] c);
        logic [SENDS_W-1:0] allowed;
        logic [2:0]         nx;
        bit                 closed;
        allowed = (cfg_max_sends == 0) ? SENDS_W'(1) : cfg_max_sends;
        closed  = 1'b0;
        if (m == MODE_START)
        begin
            link_state = LINK_WAIT;
            ua_state   = 3'd0;
            set_count  = SENDS_W'(1);
            queue_set_frame();
        end
        else if (link_state == LINK_WAIT && m == MODE_BYTE)
        begin
            nx = (c == FRAME_FLAG) ? 3'd1 : 3'd0;
            case (ua_state)
                3'd1:    if (c == ADDR_BYTE) nx = 3'd2;
                3'd2:    if (c == CTRL_UA) nx = 3'd3;
                3'd3:    if (c == UA_CHECK) nx = 3'd4;
                3'd4:
                begin
                    closed = (c == FRAME_FLAG);
                    nx     = 3'd0;
                end
                3'd0:    ;
                default: nx = 3'd0;
            endcase
            ua_state = nx;
            if (closed)
            begin
                link_state = LINK_UP;
                ticks_left = '0;
                queue_status(KIND_UP);
            end
        end
        else if (link_state == LINK_WAIT && m == MODE_TICK)
        begin
            if (ticks_left > 1)
            begin
                ticks_left = ticks_left - 1'b1;
            end
            else
            begin
                ticks_left = '0;
                if (set_count < allowed)
                begin
                    set_count = set_count + 1'b1;
                    queue_set_frame();
                end
                else
                begin
                    link_state = LINK_FAILED;
                    queue_status(KIND_FAIL);
                end
            end
        end
    endtask

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] c);
        int unsigned gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.mode    <= m;
        in_bus.rx_byte <= c;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
        predict_beat(m, c);
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        if (idx == CFG_TIMEOUT_TICKS)
            cfg_timeout = value;
        else if (idx == CFG_MAX_SENDS)
            cfg_max_sends = value[SENDS_W-1:0];
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] timeout_v,
                             input logic [CFG_DATA_W-1:0] sends_v);
        wait_idle();
        write_register(CFG_TIMEOUT_TICKS, timeout_v);
        write_register(CFG_MAX_SENDS, sends_v);
    endtask

    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            send_item(MODE_BYTE, UA_FRAME[BYTE_W*(4-ua_pos) +: BYTE_W]);
            ua_pos = (ua_pos == 4) ? 0 : ua_pos + 1;
        end
        else if (r < 65)
            send_item(MODE_TICK, BYTE_W'($urandom_range(0, 255)));
        else if (r < 78)
            send_item(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
        else if (r < 84)
        begin
            send_item(MODE_BYTE, FRAME_FLAG);
            ua_pos = 1;
        end
        else if (r < 90)
            send_item(MODE_IGNORED, BYTE_W'($urandom_range(0, 255)));
        else
        begin
            send_item(MODE_START, BYTE_W'($urandom_range(0, 255)));
            ua_pos = 0;
        end
        random_items++;
    endtask

    task automatic random_round();
        int unsigned len;
        int unsigned pick;
        logic [CFG_DATA_W-1:0] timeout_v;
        if ($urandom_range(0, 2) == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                timeout_v = '0;
            else if (pick == 1)
                timeout_v = 16'hFFFF;
            else if (pick == 2)
                timeout_v = CFG_DATA_W'($urandom_range(0, 65535));
            else
                timeout_v = CFG_DATA_W'($urandom_range(1, 5));
            configure(timeout_v, CFG_DATA_W'($urandom_range(0, 15)));
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            wait_idle();
        end
        send_item(MODE_START, BYTE_W'($urandom_range(0, 255)));
        ua_pos = 0;
        len = $urandom_range(10, 30);
        repeat (len) send_random_item();
    endtask

    task automatic test_idle_ignored();
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_IGNORED, 8'h00);
    endtask

    task automatic test_parser_paths();
        send_item(MODE_START, 8'hFF);
        send_item(MODE_BYTE, FRAME_FLAG);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, FRAME_FLAG);
        send_item(MODE_BYTE, ADDR_BYTE);
        send_item(MODE_BYTE, FRAME_FLAG);
        send_item(MODE_BYTE, ADDR_BYTE);
        send_item(MODE_BYTE, CTRL_UA);
        send_item(MODE_TICK, 8'hFF);
        send_item(MODE_BYTE, UA_CHECK);
        send_item(MODE_BYTE, FRAME_FLAG);
        send_item(MODE_TICK, 8'h00);
    endtask

    task automatic test_expiry_limits();
        configure(16'h0000, 16'h0000);
        send_item(MODE_START, 8'h00);
        send_item(MODE_TICK, 8'h00);
        configure(16'hFFFF, 16'h000F);
        send_item(MODE_START, 8'h00);
        send_item(MODE_TICK, 8'h00);
        configure(16'h0001, 16'h0002);
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, FRAME_FLAG);
        send_item(MODE_BYTE, ADDR_BYTE);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_BYTE, CTRL_UA);
        send_item(MODE_BYTE, UA_CHECK);
        send_item(MODE_BYTE, FRAME_FLAG);
    endtask

    task automatic test_random_rounds();
        random_items = 0;
        while (random_items < 185)
            random_round();
    endtask

    task automatic test_quiet_tail();
        configure(16'h0002, 16'h0003);
        calm = 1'b1;
        random_items = 0;
        while (random_items < 25)
            random_round();
    endtask

    initial
    begin : sink_stall
        int unsigned hold;
        hold       = 0;
        sink_level = 1;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                sink_level = $urandom_range(0, 3);
            if (hold != 0)
            begin
                out_bus.ready <= 1'b0;
                hold--;
            end
            else if (!calm && $urandom_range(0, 15) < sink_level)
            begin
                out_bus.ready <= 1'b0;
                hold = $urandom_range(0, 10);
            end
            else
            begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        result_beat_t want;
        if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch("result beat with none expected, kind", 0, out_bus.kind);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_bus.kind !== want.kind)
                    report_mismatch("kind", want.kind, out_bus.kind);
                if (out_bus.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", want.tx_byte, out_bus.tx_byte);
                if (out_bus.last !== want.last)
                    report_mismatch("last", want.last, out_bus.last);
            end
        end
    end

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        calm          = 1'b0;
        ua_pos        = 0;
        link_state    = LINK_IDLE;
        ua_state      = 3'd0;
        ticks_left    = '0;
        set_count     = '0;
        cfg_timeout   = TIMEOUT_RESET;
        cfg_max_sends = MAX_SENDS_RESET;
        rst_n          = 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.mode    <= MODE_START;
        in_bus.rx_byte <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= CFG_TIMEOUT_TICKS;
        cfg_bus.data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ignored();
        test_parser_paths();
        test_expiry_limits();
        test_random_rounds();
        test_quiet_tail();

        wait_idle();
        repeat (10) @(posedge clk);
        if (pending_beats.size() != 0)
            report_mismatch("expected beats left over", 0, pending_beats.size());
        if (error_count == 0)
            $display("PASS link_open_set_ua_handshake_unit");
        else
            $display("FAIL link_open_set_ua_handshake_unit");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/losu_pkg.sv
rtl/losu_if.sv
rtl/losu_core.sv
rtl/losu_tx.sv
rtl/link_open_set_ua_handshake_unit.sv
tb/tb_link_open_set_ua_handshake_unit.sv
